### rtl/core/mhc_pkg.sv
// shared constants, types and helper functions of the mandelbrot histogram color block
package mhc_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int MAX_HALF_HEIGHT = 128;
	localparam int MAX_ITER = 1024;

	localparam int PX_W = $clog2(MAX_WIDTH);
	localparam int PY_W = $clog2(MAX_HALF_HEIGHT);
	localparam int CNT_W = 10;
	localparam int HIST_AW = $clog2(MAX_ITER);
	localparam int SLOT_W = PX_W + PY_W;
	localparam int SLOT_DEPTH = MAX_WIDTH * MAX_HALF_HEIGHT;
	localparam int FRAME_W = 9;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int FIX_W = 32;
	localparam int HCNT_W = 16;
	localparam int SUM_W = HCNT_W + HIST_AW;
	localparam int DIV_W = SUM_W + 16;
	localparam int DIVR_W = 16;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	localparam logic [1:0] KIND_COMPUTE = 2'd0;
	localparam logic [1:0] KIND_COLOR = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd2;

	localparam logic [1:0] MUL_RR = 2'd0;
	localparam logic [1:0] MUL_II = 2'd1;
	localparam logic [1:0] MUL_RI = 2'd2;

	// q4.28 constants
	localparam logic signed [FIX_W-1:0] FIX_M2P5 = 32'shD8000000;
	localparam logic signed [FIX_W-1:0] FIX_M1 = 32'shF0000000;
	localparam logic signed [36:0] FIX_4 = 37'sh0040000000;

	typedef enum logic [4:0] {
		ST_RCLR,
		ST_IDLE,
		ST_DISPATCH,
		ST_C_DIVRE,
		ST_C_DIVIM,
		ST_C_M0,
		ST_C_M1,
		ST_C_M2,
		ST_C_UPD,
		ST_C_HRD,
		ST_C_HWR,
		ST_K_HRD,
		ST_K_CHK,
		ST_K_SUM,
		ST_K_TAIL,
		ST_K_DSTART,
		ST_K_DIV,
		ST_CLR,
		ST_DONE
	} mhc_state_t;

	typedef struct packed {
		logic load_item;
		logic div_start_re;
		logic div_start_im;
		logic div_start_hue;
		logic cr_latch;
		logic ci_latch;
		logic iter_init;
		logic iter_update;
		logic mul_en;
		logic [1:0] mul_sel;
		logic hist_rd;
		logic hist_wr_inc;
		logic hst_rd;
		logic cnt_from_hst;
		logic sum_init;
		logic sum_rd;
		logic sum_acc;
		logic hue_latch;
		logic clr_init;
		logic clr_step;
		logic out_load;
	} mhc_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic div_done;
		logic iter_stop;
		logic esc;
		logic clr_last;
		logic sum_last;
		logic in_set;
		logic out_free;
	} mhc_sts_t;

	function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [43:0] v);
		logic ovf;
		ovf = (v[43:FIX_W-1] != {(44-FIX_W+1){v[43]}});
		if (ovf) begin
			return v[43] ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
		end
		return v[FIX_W-1:0];
	endfunction

	function automatic logic [7:0] ramp(input logic [14:0] v);
		logic [22:0] p;
		p = 23'(v) * 23'd255;
		return p[21:14];
	endfunction

	// returns {red, green, blue}
	function automatic logic [23:0] palette(input logic [15:0] hue);
		logic [7:0] rise;
		logic [7:0] fall;
		rise = ramp({1'b0, hue[13:0]});
		fall = ramp(15'd16384 - {1'b0, hue[13:0]});
		case (hue[15:14])
			2'd0: return {8'd0, rise, 8'd255};
			2'd1: return {8'd0, 8'd255, fall};
			2'd2: return {rise, 8'd255, 8'd0};
			2'd3: return {8'd255, fall, 8'd0};
			default: return 24'd0;
		endcase
	endfunction

endpackage

### rtl/core/mhc_item_if.sv
// input word channel: step kind and pixel position
interface mhc_item_if import mhc_pkg::*;;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [PX_W-1:0] pixel_x;
	logic [PY_W-1:0] pixel_y;

	modport source(output valid, kind, pixel_x, pixel_y, input ready);
	modport sink(input valid, kind, pixel_x, pixel_y, output ready);
endinterface

### rtl/core/mhc_result_if.sv
// result word channel: escape count, inside flag and color
interface mhc_result_if import mhc_pkg::*;;
	logic valid;
	logic ready;
	logic [CNT_W-1:0] escape_count;
	logic inside_set;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, escape_count, inside_set, red, green, blue, input ready);
	modport sink(input valid, escape_count, inside_set, red, green, blue, output ready);
endinterface

### rtl/core/mhc_cfg_if.sv
// configuration write channel
interface mhc_cfg_if import mhc_pkg::*;;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/mhc_datapath.sv
// datapath: config registers, divider, escape iteration, histogram and history memories
module mhc_datapath import mhc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mhc_cmd_t              cmd,
	output mhc_sts_t              sts,
	input  logic [1:0]            in_kind,
	input  logic [PX_W-1:0]       in_px,
	input  logic [PY_W-1:0]       in_py,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [CNT_W-1:0]      out_count,
	output logic                  out_inside,
	output logic [7:0]            out_red,
	output logic [7:0]            out_green,
	output logic [7:0]            out_blue
);

	logic [FRAME_W-1:0] fw_q, fh_q;
	logic [CNT_W-1:0] mi_q;

	logic [1:0] kind_q;
	logic [PX_W-1:0] px_q;
	logic [PY_W-1:0] py_q;

	logic [DIV_W-1:0] dq_q;
	logic [DIVR_W:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [DIVR_W:0] rem_nx;
	logic [DIV_W-1:0] div_num;
	logic [DIVR_W-1:0] div_den;
	logic [FRAME_W-1:0] w_m1, h_m1;
	logic [37:0] re_num;

	logic signed [FIX_W-1:0] cr_q, ci_q, zr_q, zi_q;
	logic signed [35:0] sr_q, si_q;
	logic signed [36:0] pi_q;
	logic signed [FIX_W-1:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic signed [36:0] mag;
	logic [CNT_W-1:0] n_q;

	logic [HCNT_W-1:0] hist_mem [MAX_ITER];
	logic [HCNT_W-1:0] hist_rd_q;
	logic h_we, h_re;
	logic [HIST_AW-1:0] h_wa, h_ra;
	logic [HCNT_W-1:0] h_wd;
	logic [HIST_AW-1:0] clr_q;

	logic [CNT_W-1:0] hst_mem [SLOT_DEPTH];
	logic [CNT_W-1:0] hst_rd_q;
	logic [SLOT_W-1:0] slot;

	logic [HCNT_W-1:0] et_q;
	logic [SUM_W-1:0] sum_q;
	logic [HIST_AW-1:0] i_q;
	logic rd_pend_q;
	logic [15:0] hue_q;

	logic out_valid_q;
	logic [CNT_W-1:0] count_q;
	logic inside_q;
	logic [23:0] rgb_q;
	logic in_set;
	logic has_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 9'd256;
			fh_q <= 9'd256;
			mi_q <= 10'd100;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: fw_q <= cfg_data[FRAME_W-1:0];
				CFG_FRAME_HEIGHT: fh_q <= cfg_data[FRAME_W-1:0];
				CFG_MAX_ITER: mi_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= in_kind;
			px_q <= in_px;
			py_q <= in_py;
		end
	end

	// shared restoring divider, one quotient bit per cycle
	assign w_m1 = (fw_q < 9'd2) ? 9'd1 : fw_q - 9'd1;
	assign h_m1 = (fh_q < 9'd2) ? 9'd1 : fh_q - 9'd1;
	assign re_num = {11'(px_q) * 11'd7, 27'd0};
	assign rem_nx = {rem_q[DIVR_W-1:0], dq_q[DIV_W-1]};

	always_comb begin
		div_num = {sum_q, 16'd0};
		div_den = et_q;
		if (cmd.div_start_re) begin
			div_num = DIV_W'(re_num);
			div_den = DIVR_W'(w_m1);
		end else if (cmd.div_start_im) begin
			div_num = DIV_W'({py_q, 29'd0});
			div_den = DIVR_W'(h_m1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start_re || cmd.div_start_im || cmd.div_start_hue) begin
			dcnt_q <= DCNT_W'(DIV_W);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start_re || cmd.div_start_im || cmd.div_start_hue) begin
			dq_q <= div_num;
			rem_q <= '0;
			dvs_q <= div_den;
		end else if (dcnt_q != '0) begin
			if (rem_nx >= {1'b0, dvs_q}) begin
				rem_q <= rem_nx - {1'b0, dvs_q};
				dq_q <= {dq_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_nx;
				dq_q <= {dq_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	// escape iteration, one shared multiplier
	assign mul_a = (cmd.mul_sel == MUL_II) ? zi_q : zr_q;
	assign mul_b = (cmd.mul_sel == MUL_RR) ? zr_q : zi_q;
	assign prod = mul_a * mul_b;
	assign mag = 37'(sr_q) + 37'(si_q);

	always_ff @(posedge clk) begin
		if (cmd.cr_latch) begin
			cr_q <= sat_fix(44'({2'b0, dq_q}) + 44'(FIX_M2P5));
		end
		if (cmd.ci_latch) begin
			ci_q <= sat_fix(44'({2'b0, dq_q}) + 44'(FIX_M1));
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MUL_RR: sr_q <= prod[63:28];
				MUL_II: si_q <= prod[63:28];
				MUL_RI: pi_q <= prod[63:27];
				default: ;
			endcase
		end
		if (cmd.iter_init) begin
			zr_q <= '0;
			zi_q <= '0;
			n_q <= '0;
		end else if (cmd.iter_update) begin
			zr_q <= sat_fix(44'(sr_q) - 44'(si_q) + 44'(cr_q));
			zi_q <= sat_fix(44'(pi_q) + 44'(ci_q));
			n_q <= n_q + 1'b1;
		end else if (cmd.cnt_from_hst) begin
			n_q <= hst_rd_q;
		end
	end

	// histogram memory
	assign h_we = cmd.clr_step || cmd.hist_wr_inc;
	assign h_wa = cmd.clr_step ? clr_q : n_q[HIST_AW-1:0];
	assign h_wd = cmd.clr_step ? '0 :
		((hist_rd_q == '1) ? hist_rd_q : hist_rd_q + 1'b1);
	assign h_re = cmd.hist_rd || cmd.sum_rd;
	assign h_ra = cmd.sum_rd ? i_q : n_q[HIST_AW-1:0];

	always_ff @(posedge clk) begin
		if (h_we) begin
			hist_mem[h_wa] <= h_wd;
		end
		if (h_re) begin
			hist_rd_q <= hist_mem[h_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			et_q <= '0;
		end else begin
			if (cmd.clr_init) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.clr_init) begin
				et_q <= '0;
			end else if (cmd.hist_wr_inc && !in_set && et_q != '1) begin
				et_q <= et_q + 1'b1;
			end
		end
	end

	// per-pixel count history
	assign slot = {py_q, px_q};

	always_ff @(posedge clk) begin
		if (cmd.hist_wr_inc) begin
			hst_mem[slot] <= n_q;
		end
		if (cmd.hst_rd) begin
			hst_rd_q <= hst_mem[slot];
		end
	end

	// cumulative histogram walk, read data is registered and arrives the cycle after its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= cmd.sum_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_init) begin
			sum_q <= '0;
			i_q <= '0;
		end else begin
			if (cmd.sum_rd) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.sum_acc && rd_pend_q) begin
				sum_q <= sum_q + SUM_W'(hist_rd_q);
			end
		end
		if (cmd.hue_latch) begin
			if (et_q == '0) begin
				hue_q <= '0;
			end else if (dq_q > DIV_W'(16'hFFFF)) begin
				hue_q <= 16'hFFFF;
			end else begin
				hue_q <= dq_q[15:0];
			end
		end
	end

	// output register
	assign in_set = (n_q == mi_q);
	assign has_count = (kind_q == KIND_COMPUTE) || (kind_q == KIND_COLOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			count_q <= has_count ? n_q : '0;
			inside_q <= has_count && in_set;
			rgb_q <= (kind_q == KIND_COLOR && !in_set) ? palette(hue_q) : 24'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_count = count_q;
	assign out_inside = inside_q;
	assign out_red = rgb_q[23:16];
	assign out_green = rgb_q[15:8];
	assign out_blue = rgb_q[7:0];

	assign sts.kind = kind_q;
	assign sts.div_done = (dcnt_q == '0);
	assign sts.iter_stop = (n_q >= mi_q);
	assign sts.esc = (mag >= FIX_4);
	assign sts.clr_last = (clr_q == '1);
	assign sts.sum_last = (i_q == n_q[HIST_AW-1:0]);
	assign sts.in_set = in_set;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

### rtl/core/mhc_ctrl.sv
// controller state machine sequencing the datapath for each step kind
module mhc_ctrl import mhc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  mhc_sts_t   sts,
	output mhc_cmd_t   cmd,
	output mhc_state_t state
);

	mhc_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RCLR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_RCLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nx = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.kind)
					KIND_COMPUTE: begin
						cmd.div_start_re = 1'b1;
						state_nx = ST_C_DIVRE;
					end
					KIND_COLOR: begin
						cmd.hst_rd = 1'b1;
						state_nx = ST_K_HRD;
					end
					KIND_CLEAR: begin
						cmd.clr_init = 1'b1;
						state_nx = ST_CLR;
					end
					default: state_nx = ST_DONE;
				endcase
			end
			ST_C_DIVRE: begin
				if (sts.div_done) begin
					cmd.cr_latch = 1'b1;
					cmd.div_start_im = 1'b1;
					state_nx = ST_C_DIVIM;
				end
			end
			ST_C_DIVIM: begin
				if (sts.div_done) begin
					cmd.ci_latch = 1'b1;
					cmd.iter_init = 1'b1;
					state_nx = ST_C_M0;
				end
			end
			ST_C_M0: begin
				if (sts.iter_stop) begin
					state_nx = ST_C_HRD;
				end else begin
					cmd.mul_en = 1'b1;
					cmd.mul_sel = MUL_RR;
					state_nx = ST_C_M1;
				end
			end
			ST_C_M1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_II;
				state_nx = ST_C_M2;
			end
			ST_C_M2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_RI;
				state_nx = ST_C_UPD;
			end
			ST_C_UPD: begin
				if (sts.esc) begin
					state_nx = ST_C_HRD;
				end else begin
					cmd.iter_update = 1'b1;
					state_nx = ST_C_M0;
				end
			end
			ST_C_HRD: begin
				cmd.hist_rd = 1'b1;
				state_nx = ST_C_HWR;
			end
			ST_C_HWR: begin
				cmd.hist_wr_inc = 1'b1;
				state_nx = ST_DONE;
			end
			ST_K_HRD: begin
				cmd.cnt_from_hst = 1'b1;
				state_nx = ST_K_CHK;
			end
			ST_K_CHK: begin
				if (sts.in_set) begin
					state_nx = ST_DONE;
				end else begin
					cmd.sum_init = 1'b1;
					state_nx = ST_K_SUM;
				end
			end
			ST_K_SUM: begin
				cmd.sum_rd = 1'b1;
				cmd.sum_acc = 1'b1;
				if (sts.sum_last) begin
					state_nx = ST_K_TAIL;
				end
			end
			ST_K_TAIL: begin
				cmd.sum_acc = 1'b1;
				state_nx = ST_K_DSTART;
			end
			ST_K_DSTART: begin
				cmd.div_start_hue = 1'b1;
				state_nx = ST_K_DIV;
			end
			ST_K_DIV: begin
				if (sts.div_done) begin
					cmd.hue_latch = 1'b1;
					state_nx = ST_DONE;
				end
			end
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	assign state = state_q;

endmodule

### rtl/core/mandelbrot_histogram_color_top.sv
// compute: two divides for c, then iterations through the M0, M1, M2 and UPD states
// on one multiplier until the limit is reached or the point escapes
// color: a cumulative histogram sum, one read per cycle, then a hue divide; skipped if inside
// clear: one histogram entry zeroed per cycle; a stalled result holds the done state
// one word at a time; the next word is taken while the result still waits in the output register
// after reset the histogram is cleared before any word is taken; config taken at once
module mandelbrot_histogram_color_top import mhc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	mhc_item_if.sink     item,
	mhc_result_if.source result,
	mhc_cfg_if.sink      cfg
);

	mhc_cmd_t cmd;
	mhc_sts_t sts;
	mhc_state_t state;

	assign cfg.ready = 1'b1;

	mhc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	mhc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_kind    (item.kind),
		.in_px      (item.pixel_x),
		.in_py      (item.pixel_y),
		.cfg_valid  (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.out_count  (result.escape_count),
		.out_inside (result.inside_set),
		.out_red    (result.red),
		.out_green  (result.green),
		.out_blue   (result.blue)
	);

`ifndef SYNTHESIS
	// black for pixels inside the set
	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.inside_set |-> result.red == 8'd0 && result.blue == 8'd0
			&& result.green == 8'd0)
		else $error("inside pixel not black");

	// one word at a time: busy right after a word is taken
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready && state == ST_DISPATCH)
		else $error("word taken while busy");

	// a result is only loaded from the done state
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> state == ST_DONE && sts.out_free)
		else $error("result loaded outside done");
`endif

endmodule
